FILE: src/s5st_pkg.sv
package s5st_pkg;

    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int WORD_W    = 16;
    localparam int SLP_SHIFT = 10;
    localparam int VAL_W     = WORD_W - SLP_SHIFT;
    localparam int WIN_DEPTH = 5;
    localparam int SEEN_W    = 3;
    localparam int SKIP_W    = 3;

    localparam logic [BYTE_W-1:0] CH_UNDER   = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_S       = 8'h53;
    localparam logic [BYTE_W-1:0] CH_FIVE    = 8'h35;
    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] OP_NAME    = 8'h08;
    localparam logic [BYTE_W-1:0] OP_BYTEPFX = 8'h0A;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_PARSE_ERR = 2'd1,
        ST_ABSENT    = 2'd2,
        ST_TRUNC     = 2'd3
    } status_t;

    typedef enum logic [8:0] {
        PH_SCAN   = 9'b000000001,
        PH_OPCODE = 9'b000000010,
        PH_LEAD   = 9'b000000100,
        PH_SKIP   = 9'b000001000,
        PH_A      = 9'b000010000,
        PH_A_VAL  = 9'b000100000,
        PH_B      = 9'b001000000,
        PH_B_VAL  = 9'b010000000,
        PH_DONE   = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic hit;
        logic prefix_ok;
    } s5st_match_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } s5st_win_ctl_t;

    function automatic logic [WORD_W-1:0] sleep_word(input logic [BYTE_W-1:0] v);
        sleep_word = {v[VAL_W-1:0], {SLP_SHIFT{1'b0}}};
    endfunction

endpackage

FILE: src/s5st_name_match.sv
module s5st_name_match (
    input  logic                     clk,
    input  logic                     rst_n,
    input  s5st_pkg::s5st_win_ctl_t  ctl,
    input  logic [7:0]               data_byte,
    output s5st_pkg::s5st_match_t    match
);
    import s5st_pkg::*;

    logic [BYTE_W-1:0] win_reg  [WIN_DEPTH];
    logic [BYTE_W-1:0] win_next [WIN_DEPTH];
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;

    always_comb
    begin
        match.hit = (seen_reg >= SEEN_W'(3)) && (win_reg[2] == CH_UNDER)
                 && (win_reg[1] == CH_S) && (win_reg[0] == CH_FIVE)
                 && (data_byte == CH_UNDER);
        match.prefix_ok = ((seen_reg >= SEEN_W'(4)) && (win_reg[3] == OP_NAME))
                       || ((seen_reg >= SEEN_W'(5)) && (win_reg[4] == OP_NAME)
                           && (win_reg[3] == CH_BSLASH));
    end

    always_comb
    begin
        win_next  = win_reg;
        seen_next = seen_reg;
        if (ctl.clear)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_next[i] = '0;
            end
            seen_next = '0;
        end
        else if (ctl.shift)
        begin
            win_next[0] = data_byte;
            for (int i = 1; i < WIN_DEPTH; i++)
            begin
                win_next[i] = win_reg[i-1];
            end
            if (seen_reg < SEEN_W'(WIN_DEPTH))
            begin
                seen_next = seen_reg + SEEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
            seen_reg <= '0;
        end
        else
        begin
            win_reg  <= win_next;
            seen_reg <= seen_next;
        end
    end

endmodule

FILE: src/aml_s5_sleep_type_scanner_core.sv
// Scans an ACPI definition block, one byte per transaction, for the first _S5_ name
// (prefixed by 0x08 or 0x08 and a backslash) and returns its two sleep-type words
// shifted into register position. Exactly one result per block: found, parse error,
// not present (on the last byte) or truncated. Every byte is handled in the cycle it
// is accepted, so a byte can be taken every clock. The single output register frees in
// the same cycle its result is taken, so input keeps flowing while out_ready is high;
// a result left waiting with out_ready low holds off input until it is taken.
module aml_s5_sleep_type_scanner_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [s5st_pkg::STATUS_W-1:0] status,
    output logic [s5st_pkg::WORD_W-1:0]   sleep_type_a,
    output logic [s5st_pkg::WORD_W-1:0]   sleep_type_b
);
    import s5st_pkg::*;

    phase_t             phase_reg, phase_next, phase_step;
    logic [SKIP_W-1:0]  skip_reg, skip_next;
    logic [VAL_W-1:0]   held_a_reg, held_a_next;
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg;
    logic [WORD_W-1:0]  type_a_reg, type_b_reg;

    logic               in_fire;
    logic               emit;
    status_t            emit_status;
    logic [WORD_W-1:0]  emit_a, emit_b;
    s5st_win_ctl_t      win_ctl;
    s5st_match_t        match;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign win_ctl.shift = in_fire && (phase_reg == PH_SCAN);
    assign win_ctl.clear = in_fire && last_byte;

    s5st_name_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (win_ctl),
        .data_byte (data_byte),
        .match     (match)
    );

    always_comb
    begin
        phase_step  = phase_reg;
        skip_next   = skip_reg;
        held_a_next = held_a_reg;
        emit        = 1'b0;
        emit_status = ST_ABSENT;
        emit_a      = '0;
        emit_b      = '0;
        case (phase_reg)
            PH_SCAN:
            begin
                if (match.hit)
                begin
                    if (match.prefix_ok)
                    begin
                        phase_step = PH_OPCODE;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = ST_PARSE_ERR;
                        phase_step  = PH_DONE;
                    end
                end
                else if (last_byte)
                begin
                    emit        = 1'b1;
                    emit_status = ST_ABSENT;
                end
            end
            PH_OPCODE:
            begin
                phase_step = PH_LEAD;
            end
            PH_LEAD:
            begin
                skip_next  = SKIP_W'(data_byte[7:6]) + SKIP_W'(1);
                phase_step = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (skip_reg != '0)
                begin
                    skip_next = skip_reg - SKIP_W'(1);
                end
                if (skip_reg <= SKIP_W'(1))
                begin
                    phase_step = PH_A;
                end
            end
            PH_A, PH_A_VAL:
            begin
                if ((phase_reg == PH_A) && (data_byte == OP_BYTEPFX))
                begin
                    phase_step = PH_A_VAL;
                end
                else
                begin
                    held_a_next = data_byte[VAL_W-1:0];
                    phase_step  = PH_B;
                end
            end
            PH_B, PH_B_VAL:
            begin
                if ((phase_reg == PH_B) && (data_byte == OP_BYTEPFX))
                begin
                    phase_step = PH_B_VAL;
                end
                else
                begin
                    emit        = 1'b1;
                    emit_status = ST_FOUND;
                    emit_a      = {held_a_reg, {SLP_SHIFT{1'b0}}};
                    emit_b      = sleep_word(data_byte);
                    phase_step  = PH_DONE;
                end
            end
            default:
            begin
                phase_step = PH_DONE;
            end
        endcase

        phase_next = phase_step;
        if (last_byte)
        begin
            if (!emit && (phase_step != PH_DONE) && (phase_step != PH_SCAN))
            begin
                emit        = 1'b1;
                emit_status = ST_TRUNC;
            end
            phase_next  = PH_SCAN;
            skip_next   = '0;
            held_a_next = '0;
        end
    end

    assign out_valid_next = (in_fire && emit) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SCAN;
            skip_reg      <= '0;
            held_a_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                phase_reg  <= phase_next;
                skip_reg   <= skip_next;
                held_a_reg <= held_a_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            status_reg <= emit_status;
            type_a_reg <= emit_a;
            type_b_reg <= emit_b;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign sleep_type_a = type_a_reg;
    assign sleep_type_b = type_b_reg;

    a_last_restarts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_byte) |=> (phase_reg == PH_SCAN))
        else $error("scan phase not restored after last byte");

    a_value_emits_found: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (phase_reg == PH_B_VAL)) |=> (out_valid_reg && (status_reg == ST_FOUND)))
        else $error("second value did not produce a found result");

    a_words_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_FOUND)) |-> ((type_a_reg == '0) && (type_b_reg == '0)))
        else $error("sleep-type words nonzero without found status");

    a_empty_output_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

endmodule

FILE: tb/aml_s5_sleep_type_scanner_core_tb.sv
module aml_s5_sleep_type_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import s5st_pkg::*;

    localparam int RESET_CYCLES = 9;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FINAL_WAIT   = 2000;

    typedef logic [BYTE_W-1:0] byte_q_t [$];

    typedef struct packed {
        status_t             st;
        logic [WORD_W-1:0]   type_a;
        logic [WORD_W-1:0]   type_b;
    } scan_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     data_byte;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [STATUS_W-1:0]   status;
    logic [WORD_W-1:0]     sleep_type_a;
    logic [WORD_W-1:0]     sleep_type_b;

    logic [BYTE_W-1:0]     name_window [6];
    logic [2:0]            window_fill;
    phase_t                scan_phase;
    logic [2:0]            bytes_to_skip;
    logic [WORD_W-1:0]     first_type_word;

    scan_result_t          pending_results [$];
    int                    fail_count = 0;
    int unsigned           cycle_count = 0;
    logic                  tx_idle;
    logic                  rx_idle;

    aml_s5_sleep_type_scanner_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .sleep_type_a (sleep_type_a),
        .sleep_type_b (sleep_type_b)
    );

    always #4 clk = ~clk;

    function automatic logic [WORD_W-1:0] type_word(input logic [BYTE_W-1:0] v);
        logic [31:0] wide;
        wide = {24'h0, v} << 10;
        return wide[WORD_W-1:0];
    endfunction

    task automatic clear_scan_state();
        for (int i = 0; i < 6; i++)
        begin
            name_window[i] = '0;
        end
        window_fill     = '0;
        scan_phase      = PH_SCAN;
        bytes_to_skip   = '0;
        first_type_word = '0;
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
        scan_result_t res;
        logic         emitted;
        logic         hit;
        logic         prefix_good;
        res     = '0;
        emitted = 1'b0;
        case (scan_phase)
            PH_SCAN:
            begin
                for (int i = 5; i > 0; i--)
                begin
                    name_window[i] = name_window[i-1];
                end
                name_window[0] = b;
                if (window_fill < 3'd6)
                begin
                    window_fill++;
                end
                hit = window_fill >= 3'd4 && name_window[3] == CH_UNDER
                   && name_window[2] == CH_S && name_window[1] == CH_FIVE
                   && name_window[0] == CH_UNDER;
                if (hit)
                begin
                    prefix_good = (window_fill >= 3'd5 && name_window[4] == OP_NAME)
                               || (window_fill >= 3'd6 && name_window[5] == OP_NAME
                                   && name_window[4] == CH_BSLASH);
                    if (prefix_good)
                    begin
                        scan_phase = PH_OPCODE;
                    end
                    else
                    begin
                        res.st     = ST_PARSE_ERR;
                        emitted    = 1'b1;
                        scan_phase = PH_DONE;
                    end
                end
                else if (last)
                begin
                    res.st  = ST_ABSENT;
                    emitted = 1'b1;
                end
            end
            PH_OPCODE:
            begin
                scan_phase = PH_LEAD;
            end
            PH_LEAD:
            begin
                bytes_to_skip = {1'b0, b[7:6]} + 3'd1;
                scan_phase    = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (bytes_to_skip != 3'd0)
                begin
                    bytes_to_skip--;
                end
                if (bytes_to_skip == 3'd0)
                begin
                    scan_phase = PH_A;
                end
            end
            PH_A, PH_A_VAL:
            begin
                if (scan_phase == PH_A && b == OP_BYTEPFX)
                begin
                    scan_phase = PH_A_VAL;
                end
                else
                begin
                    first_type_word = type_word(b);
                    scan_phase      = PH_B;
                end
            end
            PH_B, PH_B_VAL:
            begin
                if (scan_phase == PH_B && b == OP_BYTEPFX)
                begin
                    scan_phase = PH_B_VAL;
                end
                else
                begin
                    res.st     = ST_FOUND;
                    res.type_a = first_type_word;
                    res.type_b = type_word(b);
                    emitted    = 1'b1;
                    scan_phase = PH_DONE;
                end
            end
            default:
            begin
                scan_phase = PH_DONE;
            end
        endcase
        if (last)
        begin
            if (!emitted && scan_phase != PH_DONE && scan_phase != PH_SCAN)
            begin
                res     = '0;
                res.st  = ST_TRUNC;
                emitted = 1'b1;
            end
            clear_scan_state();
        end
        if (emitted)
        begin
            pending_results.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_byte(data_byte, last_byte);
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with none pending", 32'h0, {30'h0, status});
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                    begin
                        report_mismatch("status", {30'h0, want.st}, {30'h0, status});
                    end
                    if (sleep_type_a !== want.type_a)
                    begin
                        report_mismatch("sleep_type_a", {16'h0, want.type_a},
                                        {16'h0, sleep_type_a});
                    end
                    if (sleep_type_b !== want.type_b)
                    begin
                        report_mismatch("sleep_type_b", {16'h0, want.type_b},
                                        {16'h0, sleep_type_b});
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned hold;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = rx_idle ? $urandom_range(0, 15) : 0;
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_block(input byte_q_t blk, inout int sent);
        for (int i = 0; i < blk.size(); i++)
        begin
            send_byte(blk[i], i == blk.size() - 1);
            sent++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_name_byte();
        case ($urandom_range(0, 9))
            0: return OP_NAME;
            1: return CH_BSLASH;
            2: return CH_UNDER;
            3: return CH_S;
            4: return CH_FIVE;
            5: return OP_BYTEPFX;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic byte_q_t make_noise_block();
        byte_q_t blk;
        int unsigned len;
        len = $urandom_range(1, 24);
        repeat (len) blk.push_back(pick_name_byte());
        return blk;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_value();
        return ($urandom_range(0, 7) == 0) ? OP_BYTEPFX : 8'($urandom);
    endfunction

    function automatic byte_q_t make_table_block();
        byte_q_t           blk;
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] other;
        int unsigned       cut;
        repeat ($urandom_range(0, 3)) blk.push_back(8'($urandom));
        other = 8'($urandom);
        if (other == OP_NAME)
        begin
            other = ~other;
        end
        case ($urandom_range(0, 6))
            0, 1, 2: blk.push_back(OP_NAME);
            3, 4:
            begin
                blk.push_back(OP_NAME);
                blk.push_back(CH_BSLASH);
            end
            5: blk.push_back(other);
            default:
            begin
                blk.push_back(other);
                blk.push_back(CH_BSLASH);
            end
        endcase
        blk.push_back(CH_UNDER);
        blk.push_back(CH_S);
        blk.push_back(CH_FIVE);
        blk.push_back(CH_UNDER);
        blk.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h12);
        lead = 8'($urandom);
        blk.push_back(lead);
        repeat (lead[7:6]) blk.push_back(8'($urandom));
        blk.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1)
        begin
            blk.push_back(OP_BYTEPFX);
        end
        blk.push_back(pick_value());
        if ($urandom_range(0, 1) == 1)
        begin
            blk.push_back(OP_BYTEPFX);
        end
        blk.push_back(pick_value());
        repeat ($urandom_range(0, 4)) blk.push_back(pick_name_byte());
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, blk.size());
            while (blk.size() > cut) void'(blk.pop_back());
        end
        return blk;
    endfunction

    task automatic test_directed_cases();
        byte_q_t blk;
        int      sent;
        sent = 0;
        blk = '{CH_UNDER, CH_S, CH_FIVE, CH_UNDER};
        send_block(blk, sent);
        blk = '{OP_NAME, CH_UNDER, CH_S, CH_FIVE, CH_UNDER};
        send_block(blk, sent);
        blk = '{8'hFF};
        send_block(blk, sent);
        blk = '{OP_NAME, CH_BSLASH, CH_UNDER, CH_S, CH_FIVE, CH_UNDER, 8'h12, 8'hC0,
                8'h00, 8'h00, 8'h00, 8'h02, OP_BYTEPFX, 8'hFF, 8'h00};
        send_block(blk, sent);
    endtask

    task automatic test_wellformed_tables(input int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8)
            begin
                send_block(make_table_block(), sent);
            end
            else
            begin
                send_block(make_noise_block(), sent);
            end
        end
    endtask

    task automatic test_full_rate(input int target);
        int sent;
        sent = 0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        while (sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_block(make_table_block(), sent);
            end
            else
            begin
                send_block(make_noise_block(), sent);
            end
        end
    endtask

    task automatic test_noise_and_broken(input int target);
        int sent;
        sent = 0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        while (sent < target)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_block(make_noise_block(), sent);
            end
            else
            begin
                send_block(make_table_block(), sent);
            end
        end
    endtask

    initial
    begin
        int waited;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        tx_idle   = 1'b1;
        rx_idle   = 1'b1;
        clear_scan_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        drain_results();
        test_wellformed_tables(900);
        drain_results();
        test_full_rate(500);
        drain_results();
        test_noise_and_broken(400);

        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < FINAL_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("results never arrived", pending_results.size(), 32'h0);
        end
        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
